[design/rse_pkg.sv]
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types and constants for the Fisher-Yates shuffle engine.
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int ELEMENT_BITS = 32;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int GEN_W        = 64;
    localparam int PROD_W       = GEN_W + CNT_W;

    localparam logic [GEN_W-1:0] SEED_DEFAULT = 64'd234523452374537324;
    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 7;
    localparam int SHIFT_C = 17;

    typedef logic [ADDR_W-1:0] thresh_tab_t [MAX_ELEMENTS];

    // 2^64 mod b for each bound b = index + 1, by doubling
    function automatic thresh_tab_t thresh_table();
        thresh_tab_t tab;
        logic [CNT_W:0] r;
        logic [CNT_W:0] b;
        for (int e = 0; e < MAX_ELEMENTS; e++) begin
            b = (CNT_W + 1)'(e + 1);
            r = (CNT_W + 1)'(1);
            if (r >= b) r = r - b;
            for (int s = 0; s < GEN_W; s++) begin
                r = r << 1;
                if (r >= b) r = r - b;
            end
            tab[e] = r[ADDR_W-1:0];
        end
        return tab;
    endfunction

    localparam thresh_tab_t THRESH_TAB = thresh_table();

    // request from the sequencer to the draw unit
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] bound;
        logic             seed_load;
        logic [GEN_W-1:0] seed;
    } draw_req_t;

    // answer from the draw unit
    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] j;
    } draw_rsp_t;

endpackage

[design/random_shuffle_engine.sv]
// ----------------------------------------------------------------------------
// random_shuffle_engine
// Loads a set of words, shuffles it in place with Fisher-Yates, streams it out.
// ----------------------------------------------------------------------------
// Loading takes one word per cycle; the last word starts the shuffle.
// Each of the n shuffle steps runs draw attempts (xorshift step, multiply,
// check) until one is accepted, then a read-read-write-write swap in the RAM.
// Output passes each word through a RAM read, then the output register.
// Reset (synchronous, active low) empties the set and loads the default seed;
// the element RAM is not cleared.
module random_shuffle_engine (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rse_pkg::ELEMENT_BITS-1:0] s_tdata,  // [31:0] element_in
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rse_pkg::ELEMENT_BITS-1:0] m_tdata,  // [31:0] element_out
    output logic                           m_tlast,
    output logic                           m_tuser,  // [0] overflow_seen
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rse_pkg::GEN_W-1:0]      cfg_data
);
    import rse_pkg::*;

    typedef enum logic [7:0] {
        S_LOAD      = 8'b0000_0001,
        S_DRAW      = 8'b0000_0010,
        S_RD_I      = 8'b0000_0100,
        S_RD_J      = 8'b0000_1000,
        S_WR_I      = 8'b0001_0000,
        S_WR_J      = 8'b0010_0000,
        S_EMIT_RD   = 8'b0100_0000,
        S_EMIT_WAIT = 8'b1000_0000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    ovf_reg, ovf_next;
    logic [ADDR_W-1:0]       i_reg, i_next;
    logic [ADDR_W-1:0]       j_reg, j_next;
    logic [ADDR_W-1:0]       k_reg, k_next;
    logic [ELEMENT_BITS-1:0] tmp_reg, tmp_next;
    logic                    mv_reg, mv_next;
    logic [ELEMENT_BITS-1:0] mdata_reg, mdata_next;
    logic                    mlast_reg, mlast_next;
    logic                    muser_reg, muser_next;

    logic                    we;
    logic [ADDR_W-1:0]       waddr, raddr;
    logic [ELEMENT_BITS-1:0] wdata, rdata;
    draw_req_t               dreq;
    draw_rsp_t               drsp;
    logic                    s_acc;
    logic                    k_last;

    assign s_tready  = (state_reg == S_LOAD);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign k_last    = ((CNT_W'(k_reg) + CNT_W'(1)) == cnt_reg);

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;
    assign m_tuser  = muser_reg;

    rse_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(MAX_ELEMENTS)) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    rse_draw u_draw (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    // main sequencer: load, shuffle steps, emit
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        tmp_next   = tmp_reg;
        mv_next    = mv_reg && !m_tready;
        mdata_next = mdata_reg;
        mlast_next = mlast_reg;
        muser_next = muser_reg;
        we         = 1'b0;
        waddr      = ADDR_W'(cnt_reg);
        wdata      = s_tdata;
        raddr      = i_reg;
        dreq.start     = 1'b0;
        dreq.bound     = CNT_W'(i_reg) + CNT_W'(1);
        dreq.seed_load = cfg_valid;
        dreq.seed      = cfg_data;
        unique case (state_reg)
            S_LOAD: begin
                if (s_acc) begin
                    if (cnt_reg < CNT_W'(MAX_ELEMENTS)) begin
                        we       = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        i_next     = ADDR_W'(cnt_next - CNT_W'(1));
                        dreq.start = 1'b1;
                        dreq.bound = cnt_next;
                        state_next = S_DRAW;
                    end
                end
            end
            S_DRAW: begin
                if (drsp.done) begin
                    j_next     = (drsp.j <= i_reg) ? drsp.j : i_reg;
                    state_next = S_RD_I;
                end
            end
            S_RD_I: begin
                raddr      = i_reg;
                state_next = S_RD_J;
            end
            S_RD_J: begin
                raddr      = j_reg;
                tmp_next   = rdata;
                state_next = S_WR_I;
            end
            S_WR_I: begin
                we         = 1'b1;
                waddr      = i_reg;
                wdata      = rdata;
                state_next = S_WR_J;
            end
            S_WR_J: begin
                we    = 1'b1;
                waddr = j_reg;
                wdata = tmp_reg;
                if (i_reg == '0) begin
                    k_next     = '0;
                    state_next = S_EMIT_RD;
                end else begin
                    i_next     = i_reg - ADDR_W'(1);
                    dreq.start = 1'b1;
                    dreq.bound = CNT_W'(i_reg);
                    state_next = S_DRAW;
                end
            end
            S_EMIT_RD: begin
                raddr      = k_reg;
                state_next = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                raddr = k_reg;
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mdata_next = rdata;
                    mlast_next = k_last;
                    muser_next = ovf_reg;
                    if (k_last) begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end else begin
                        k_next     = k_reg + ADDR_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            mv_reg    <= mv_next;
        end
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        tmp_reg   <= tmp_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
        muser_reg <= muser_next;
    end

    // checks
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

    a_draw_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        drsp.done |-> (state_reg == S_DRAW))
        else $error("draw finished while sequencer not waiting");

    a_draw_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        drsp.done |-> (drsp.j <= i_reg))
        else $error("drawn index above current index");

    a_swap_in_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WR_J) |-> (CNT_W'(i_reg) < cnt_reg))
        else $error("swap index outside loaded set");

endmodule

[design/rse_ram.sv]
// ----------------------------------------------------------------------------
// rse_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

[design/rse_draw.sv]
// ----------------------------------------------------------------------------
// rse_draw
// xorshift64 generator with multiply-high bounded draw and rejection.
// ----------------------------------------------------------------------------
module rse_draw (
    input  logic                aclk,
    input  logic                aresetn,
    input  rse_pkg::draw_req_t  req,
    output rse_pkg::draw_rsp_t  rsp
);
    import rse_pkg::*;

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_STEP = 4'b0010,
        D_MUL  = 4'b0100,
        D_CHK  = 4'b1000
    } dstate_t;

    dstate_t           state_reg, state_next;
    logic [GEN_W-1:0]  gen_reg, gen_next;
    logic [CNT_W-1:0]  bound_reg, bound_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [GEN_W-1:0]  x0, x1, x2, x3;
    logic [ADDR_W-1:0] thresh;
    logic              reject;

    // one xorshift64 step, zero state replaced by the default seed
    always_comb begin
        x0 = (gen_reg == '0) ? SEED_DEFAULT : gen_reg;
        x1 = x0 ^ (x0 << SHIFT_A);
        x2 = x1 ^ (x1 >> SHIFT_B);
        x3 = x2 ^ (x2 << SHIFT_C);
    end

    // rejection threshold from the bound table
    always_comb begin
        thresh = THRESH_TAB[ADDR_W'(bound_reg - CNT_W'(1))];
        reject = (prod_reg[GEN_W-1:0] < {{(GEN_W-ADDR_W){1'b0}}, thresh});
    end

    // sequencing of draw, multiply and check
    always_comb begin
        state_next = state_reg;
        gen_next   = gen_reg;
        bound_next = bound_reg;
        prod_next  = prod_reg;
        rsp.done   = 1'b0;
        rsp.j      = prod_reg[GEN_W +: ADDR_W];
        unique case (state_reg)
            D_IDLE: begin
                if (req.start) begin
                    bound_next = req.bound;
                    state_next = D_STEP;
                end
            end
            D_STEP: begin
                gen_next   = x3;
                state_next = D_MUL;
            end
            D_MUL: begin
                prod_next  = PROD_W'(gen_reg) * PROD_W'(bound_reg);
                state_next = D_CHK;
            end
            D_CHK: begin
                if (reject) begin
                    state_next = D_STEP;
                end else begin
                    rsp.done   = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default: state_next = D_IDLE;
        endcase
        if (req.seed_load) begin
            gen_next = req.seed;
        end
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            gen_reg   <= SEED_DEFAULT;
        end else begin
            state_reg <= state_next;
            gen_reg   <= gen_next;
        end
        bound_reg <= bound_next;
        prod_reg  <= prod_next;
    end

endmodule
